@@ rtl/dpuf_pkg.sv @@
// Shared types, constants and helpers of the Dirac parse-unit framer.
`default_nettype none
package dpuf_pkg;

  // Width of the frame, drop and skip length counters (16 to 32).
  localparam int unsigned COUNT_BITS = 32;

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  // Parse-info header: 4 sync bytes, code, 4 offset bytes, 4 ignored bytes.
  localparam logic [3:0]  SYNC_LAST_IDX = 4'd3;
  localparam logic [3:0]  CODE_IDX      = 4'd4;
  localparam logic [3:0]  OFFSET_LAST   = 4'd8;
  localparam logic [3:0]  HDR_LAST_IDX  = 4'd12;
  localparam logic [31:0] HDR_LEN       = 32'd13;
  localparam count_t      SYNC_LEN      = COUNT_BITS'(4);
  localparam count_t      COUNT_ONE     = COUNT_BITS'(1);

  // Register reset values.
  localparam logic [31:0] SYNC_WORD_RST     = 32'h4242_4344;
  localparam logic [7:0]  PICTURE_MASK_RST  = 8'h08;
  localparam logic [7:0]  PICTURE_VALUE_RST = 8'h08;

  // Register indexes (word address paddr[3:2]).
  typedef enum logic [1:0] {
    REG_SYNC_WORD     = 2'd0,
    REG_PICTURE_MASK  = 2'd1,
    REG_PICTURE_VALUE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_FRAME = 2'd0,
    EV_DROP  = 2'd1,
    EV_SKIP  = 2'd2
  } event_t;

  function automatic count_t sat_add(count_t a, count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/dirac_parse_unit_framer.sv @@
// Dirac parse-unit framer: sync hunt, parse-info header decode and frame reporting.
//
// The block takes one stream byte per cycle on the in_ channel and gives at
// most one event per byte on the out_ channel, registered in the cycle after the
// transfer. A byte is taken in every cycle while the output register is empty
// or is being emptied in the same cycle, so the sustained rate is one byte per
// clock; a stalled output holds in_ready low until its event is taken. Event 0
// reports a completed picture frame and its length, event 1 a frame dropped
// because the sync word was missing at a chunk start, and event 2 the number
// of bytes skipped before sync was found. Lengths saturate at the counter
// maximum. Registers: sync word at 0x0, picture mask at 0x4, picture value at
// 0x8; write them only while the stream is idle.
`default_nettype none
module dirac_parse_unit_framer
  import dpuf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_stream_byte,
  // event channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [31:0]      out_byte_count,
  output logic [7:0]       out_chunk_code,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] sync_word_r;
  logic [7:0]  picture_mask_r;
  logic [7:0]  picture_value_r;

  phase_t      phase_r,  phase_nxt;
  logic [31:0] window_r, window_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  code_r,   code_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] left_r,   left_nxt;
  count_t      frame_r,  frame_nxt;
  count_t      skip_r,   skip_nxt;

  logic        out_valid_r;
  event_t      out_kind_r;
  count_t      out_count_r;
  logic [7:0]  out_code_r;

  logic        in_fire;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic        res_valid;
  event_t      res_kind;
  count_t      res_count;
  logic [7:0]  res_code;
  logic        is_picture;
  logic [31:0] left_dec;
  count_t      skipped;

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_SYNC_WORD:     prdata = sync_word_r;
      REG_PICTURE_MASK:  prdata = {24'd0, picture_mask_r};
      REG_PICTURE_VALUE: prdata = {24'd0, picture_value_r};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r     <= SYNC_WORD_RST;
      picture_mask_r  <= PICTURE_MASK_RST;
      picture_value_r <= PICTURE_VALUE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SYNC_WORD:     sync_word_r     <= pwdata;
        REG_PICTURE_MASK:  picture_mask_r  <= pwdata[7:0];
        REG_PICTURE_VALUE: picture_value_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- framing
  assign in_ready   = !out_valid_r || out_ready;
  assign in_fire    = in_valid && in_ready;
  assign is_picture = (code_r & picture_mask_r) == picture_value_r;
  assign left_dec   = (left_r != 32'd0) ? left_r - 32'd1 : 32'd0;

  always_comb begin
    phase_nxt   = phase_r;
    window_nxt  = window_r;
    hdr_idx_nxt = hdr_idx_r;
    code_nxt    = code_r;
    offset_nxt  = offset_r;
    left_nxt    = left_r;
    frame_nxt   = frame_r;
    skip_nxt    = skip_r;
    res_valid   = 1'b0;
    res_kind    = EV_FRAME;
    res_count   = frame_r;
    res_code    = code_r;
    skipped     = '0;

    if (in_fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_idx_r <= SYNC_LAST_IDX) begin
            window_nxt  = {window_r[23:0], in_stream_byte};
            hdr_idx_nxt = hdr_idx_r + 4'd1;
            if (hdr_idx_r == SYNC_LAST_IDX) begin
              if (window_nxt != sync_word_r) begin
                // lost sync: drop the frame, the 4 bytes count as hunted
                res_valid   = 1'b1;
                res_kind    = EV_DROP;
                res_count   = frame_r;
                frame_nxt   = '0;
                skip_nxt    = SYNC_LEN;
                phase_nxt   = PH_HUNT;
                hdr_idx_nxt = 4'd0;
              end else begin
                frame_nxt = sat_add(frame_r, SYNC_LEN);
              end
            end
          end else begin
            frame_nxt = sat_add(frame_r, COUNT_ONE);
            if (hdr_idx_r == CODE_IDX) begin
              code_nxt = in_stream_byte;
            end else if (hdr_idx_r <= OFFSET_LAST) begin
              offset_nxt = {offset_r[23:0], in_stream_byte};
            end
            if (hdr_idx_r >= HDR_LAST_IDX) begin
              // short offsets are taken as a bare header
              left_nxt    = (offset_r >= HDR_LEN) ? offset_r - HDR_LEN : 32'd0;
              hdr_idx_nxt = 4'd0;
              if (left_nxt == 32'd0) begin
                phase_nxt = PH_HEADER;
                if (is_picture) begin
                  res_valid = 1'b1;
                  res_kind  = EV_FRAME;
                  res_count = frame_nxt;
                  frame_nxt = '0;
                end
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end else begin
              hdr_idx_nxt = hdr_idx_r + 4'd1;
            end
          end
        end

        PH_PAYLOAD: begin
          frame_nxt = sat_add(frame_r, COUNT_ONE);
          left_nxt  = left_dec;
          if (left_dec == 32'd0) begin
            phase_nxt   = PH_HEADER;
            hdr_idx_nxt = 4'd0;
            if (is_picture) begin
              res_valid = 1'b1;
              res_kind  = EV_FRAME;
              res_count = frame_nxt;
              frame_nxt = '0;
            end
          end
        end

        default: begin
          phase_nxt  = PH_HUNT;
          window_nxt = {window_r[23:0], in_stream_byte};
          skip_nxt   = sat_add(skip_r, COUNT_ONE);
          if (skip_nxt >= SYNC_LEN && window_nxt == sync_word_r) begin
            skipped     = (skip_nxt == COUNT_MAX) ? COUNT_MAX : skip_nxt - SYNC_LEN;
            skip_nxt    = '0;
            phase_nxt   = PH_HEADER;
            hdr_idx_nxt = CODE_IDX;
            frame_nxt   = SYNC_LEN;
            offset_nxt  = 32'd0;
            if (skipped != '0) begin
              res_valid = 1'b1;
              res_kind  = EV_SKIP;
              res_count = skipped;
              res_code  = 8'd0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      window_r    <= 32'd0;
      hdr_idx_r   <= 4'd0;
      code_r      <= 8'd0;
      offset_r    <= 32'd0;
      left_r      <= 32'd0;
      frame_r     <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      window_r    <= window_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      code_r      <= code_nxt;
      offset_r    <= offset_nxt;
      left_r      <= left_nxt;
      frame_r     <= frame_nxt;
      skip_r      <= skip_nxt;
      if (in_fire) begin
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the event payload until its transfer
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_kind_r  <= res_kind;
      out_count_r <= res_count;
      out_code_r  <= res_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_byte_count = 32'(out_count_r);
  assign out_chunk_code = out_code_r;

endmodule
`default_nettype wire
